@@ hdl/assert_macros.svh @@
// Assertion macros for the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define KL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/kl_pkg.sv @@
// Types, constants and character helpers for the keyword lexer.
package kl_pkg;

	localparam int MAX_NAME_LEN = 255;
	localparam int POS_WIDTH    = 16;
	localparam int LEN_CAP      = (MAX_NAME_LEN < 255) ? MAX_NAME_LEN : 255;
	localparam int MAX_RESULTS  = 3;

	typedef enum logic [2:0] {
		KIND_NAME    = 3'd0,
		KIND_IF      = 3'd1,
		KIND_THEN    = 3'd2,
		KIND_CASE    = 3'd3,
		KIND_BR      = 3'd4,
		KIND_OP      = 3'd5,
		KIND_INVALID = 3'd6,
		KIND_END     = 3'd7
	} token_kind_t;

	typedef enum logic [3:0] {
		TRIE_ROOT = 4'd0,
		TRIE_I    = 4'd1,
		TRIE_IF   = 4'd2,
		TRIE_T    = 4'd3,
		TRIE_TH   = 4'd4,
		TRIE_THE  = 4'd5,
		TRIE_THEN = 4'd6,
		TRIE_C    = 4'd7,
		TRIE_CA   = 4'd8,
		TRIE_CAS  = 4'd9,
		TRIE_CASE = 4'd10,
		TRIE_B    = 4'd11,
		TRIE_BR   = 4'd12,
		TRIE_DEAD = 4'd15
	} trie_state_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} byte_beat_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [7:0]  token_char;
		logic [15:0] token_start;
		logic [7:0]  token_len;
		logic [15:0] line_no;
		logic        any_error;
		logic        run_last;
	} token_beat_t;

	// Tokens produced by one byte, oldest in slot 0.
	typedef struct packed {
		token_beat_t [MAX_RESULTS-1:0] tok;
		logic [1:0]                    cnt;
	} kl_batch_t;

	typedef struct packed {
		logic                 in_name;
		logic [7:0]           name_len;
		trie_state_t          trie;
		logic [POS_WIDTH-1:0] name_start;
		logic [POS_WIDTH-1:0] byte_pos;
		logic [15:0]          line_count;
		logic                 error_seen;
	} kl_state_t;

	localparam kl_state_t STATE_RESET = '{
		in_name:    1'b0,
		name_len:   8'd0,
		trie:       TRIE_ROOT,
		name_start: '0,
		byte_pos:   '0,
		line_count: 16'd1,
		error_seen: 1'b0
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_name_start(input logic [7:0] c);
		return is_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return is_name_start(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return (c == CH_COLON) || (c == CH_LPAR) || (c == CH_RPAR) ||
			(c == CH_COMMA) || (c == CH_SEMI) || (c == CH_BANG);
	endfunction

	function automatic trie_state_t trie_next(input trie_state_t s, input logic [7:0] c);
		trie_state_t n;
		n = TRIE_DEAD;
		unique case (s)
			TRIE_ROOT: begin
				if (c == 8'h69)      n = TRIE_I;   // i
				else if (c == 8'h74) n = TRIE_T;   // t
				else if (c == 8'h63) n = TRIE_C;   // c
				else if (c == 8'h62) n = TRIE_B;   // b
			end
			TRIE_I:   if (c == 8'h66) n = TRIE_IF;    // f
			TRIE_T:   if (c == 8'h68) n = TRIE_TH;    // h
			TRIE_TH:  if (c == 8'h65) n = TRIE_THE;   // e
			TRIE_THE: if (c == 8'h6E) n = TRIE_THEN;  // n
			TRIE_C:   if (c == 8'h61) n = TRIE_CA;    // a
			TRIE_CA:  if (c == 8'h73) n = TRIE_CAS;   // s
			TRIE_CAS: if (c == 8'h65) n = TRIE_CASE;  // e
			TRIE_B:   if (c == 8'h72) n = TRIE_BR;    // r
			default:  n = TRIE_DEAD;
		endcase
		return n;
	endfunction

	function automatic token_kind_t trie_kind(input trie_state_t s);
		token_kind_t k;
		unique case (s)
			TRIE_IF:   k = KIND_IF;
			TRIE_THEN: k = KIND_THEN;
			TRIE_CASE: k = KIND_CASE;
			TRIE_BR:   k = KIND_BR;
			default:   k = KIND_NAME;
		endcase
		return k;
	endfunction

endpackage

@@ hdl/kl_step.sv @@
// Per-byte scan step: next scanner state and the tokens one byte produces.
module kl_step import kl_pkg::*; (
	input  kl_state_t  cur,
	input  byte_beat_t beat,
	output kl_state_t  nxt,
	output kl_batch_t  batch
);

	token_beat_t     cand [4];
	logic [3:0]      cand_v;
	token_beat_t     slot [4];
	logic [2:0]      n;
	kl_state_t       mid;
	logic            cont;
	logic [7:0]      c;
	logic [POS_WIDTH-1:0] pos_inc;

	assign c       = beat.ch;
	assign cont    = cur.in_name && is_name_char(c);
	assign pos_inc = cur.byte_pos + POS_WIDTH'(1);

	always_comb begin
		mid         = cur;
		cand_v      = '0;
		for (int i = 0; i < 4; i++) begin
			cand[i] = '0;
		end

		// name closed by this byte
		cand[0].token_kind  = trie_kind(cur.trie);
		cand[0].token_start = 16'(cur.name_start);
		cand[0].token_len   = cur.name_len;
		cand[0].line_no     = cur.line_count;
		cand[0].any_error   = cur.error_seen;

		if (cont) begin
			if (cur.name_len < 8'(LEN_CAP)) begin
				mid.name_len = cur.name_len + 8'd1;
			end
			mid.trie = trie_next(cur.trie, c);
		end else begin
			cand_v[0]   = cur.in_name;
			mid.in_name = 1'b0;
			mid.name_len = 8'd0;
			mid.trie    = TRIE_ROOT;
			priority if (is_space(c)) begin
				if (c == CH_NL && cur.line_count < LINE_MAX) begin
					mid.line_count = cur.line_count + 16'd1;
				end
			end else if (is_name_start(c)) begin
				mid.in_name    = 1'b1;
				mid.name_len   = 8'd1;
				mid.name_start = cur.byte_pos;
				mid.trie       = trie_next(TRIE_ROOT, c);
			end else if (is_operator(c)) begin
				cand_v[1] = 1'b1;
				cand[1].token_kind = KIND_OP;
			end else begin
				cand_v[1]      = 1'b1;
				mid.error_seen = 1'b1;
				cand[1].token_kind = KIND_INVALID;
			end
		end
		mid.byte_pos = pos_inc;

		cand[1].token_char  = c;
		cand[1].token_start = 16'(cur.byte_pos);
		cand[1].token_len   = 8'd1;
		cand[1].line_no     = mid.line_count;
		cand[1].any_error   = mid.error_seen;

		// flush at end of text, then the end token
		cand_v[2] = beat.last && mid.in_name;
		cand[2].token_kind  = trie_kind(mid.trie);
		cand[2].token_start = 16'(mid.name_start);
		cand[2].token_len   = mid.name_len;
		cand[2].line_no     = mid.line_count;
		cand[2].any_error   = mid.error_seen;

		cand_v[3] = beat.last;
		cand[3].token_kind  = KIND_END;
		cand[3].token_start = 16'(pos_inc);
		cand[3].token_len   = 8'd0;
		cand[3].line_no     = mid.line_count;
		cand[3].any_error   = mid.error_seen;

		nxt = beat.last ? STATE_RESET : mid;
	end

	// pack valid candidates into the low slots
	always_comb begin
		n = 3'd0;
		for (int i = 0; i < 4; i++) begin
			slot[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				slot[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			slot[i].run_last = (3'(i + 1) == n);
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			batch.tok[i] = slot[i];
		end
		batch.cnt = n[1:0];
	end

endmodule

@@ hdl/kl_result_buf.sv @@
// Result register: holds one byte's tokens and hands them out one per beat.
module kl_result_buf import kl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  kl_batch_t   batch,
	output logic        can_load,
	output logic        tok_valid,
	input  logic        tok_ready,
	output token_beat_t tok_data
);

	token_beat_t tok_q [MAX_RESULTS];
	logic [1:0]  cnt_q;
	logic        pop;

	assign tok_valid = (cnt_q != 2'd0);
	assign tok_data  = tok_q[0];
	assign pop       = tok_valid && tok_ready;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tok_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				tok_q[i] <= batch.tok[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				tok_q[i] <= tok_q[i+1];
			end
		end
	end

endmodule

@@ hdl/keyword_lexer.sv @@
// Top level of the keyword lexer: scanner state, step logic and result register.
// A byte's first token is valid in the cycle after the byte beat is taken.
// Throughput: one byte per cycle while each byte yields at most one token and tok_ready
// is high; a byte that yields more holds the input until its last token is taken.
// Reset (arst_n low, asynchronous): scanner state to its start values (line 1,
// offset 0, no open name, error flag clear) and the result register emptied.
module keyword_lexer import kl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  byte_beat_t  byte_data,
	output logic        tok_valid,
	input  logic        tok_ready,
	output token_beat_t tok_data
);

	`include "assert_macros.svh"

	kl_state_t state_q;
	kl_state_t state_nxt;
	kl_batch_t batch;
	logic      take;

	// A byte is taken when the result register is empty or drains its last
	// token in this same cycle.
	assign take = byte_valid && byte_ready;

	kl_step u_step (
		.cur   (state_q),
		.beat  (byte_data),
		.nxt   (state_nxt),
		.batch (batch)
	);

	kl_result_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.batch     (batch),
		.can_load  (byte_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	// Scanner state advances once per accepted byte beat; the last byte of a
	// text returns it to the start values so a new text can follow directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	`KL_ASSERT_NEXT(a_last_rewinds, take && byte_data.last, state_q.byte_pos == '0 && state_q.line_count == 16'd1 && !state_q.in_name, "scanner not rewound after last byte")
	`KL_ASSERT_NOW(a_name_len_nonzero, state_q.in_name, state_q.name_len != 8'd0, "open name with zero length")
	`KL_ASSERT_NOW(a_root_when_idle, !state_q.in_name, state_q.trie == TRIE_ROOT, "trie off root with no open name")
	`KL_ASSERT_NOW(a_end_closes_run, tok_valid && tok_data.token_kind == KIND_END, tok_data.run_last, "end token not last of its byte")

endmodule
